>>> rtl/pwmpd_pkg.sv
// ============================================================================
// pwmpd_pkg
// Types, constants and helpers shared by the PWM period/duty calculator.
// ============================================================================
package pwmpd_pkg;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam int SLOT_COUNT = 4;
  localparam int NUM_W      = 32;
  localparam int DEN_W      = 48;

  localparam logic OP_SET_DUTY = 1'b0;
  localparam logic OP_SET_FREQ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [1:0]  channel;
    logic [15:0] duty;
    logic [31:0] target_frequency;
    logic [31:0] timer_clock;
  } pwmpd_request_t;

  typedef struct packed {
    logic        error;
    logic [15:0] prescale;
    logic [15:0] reload;
    logic [15:0] compare_one;
    logic [15:0] compare_two;
    logic [15:0] compare_three;
    logic [15:0] compare_four;
  } pwmpd_result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } pwmpd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } pwmpd_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUTY_MUL,
    ST_DUTY_DIV,
    ST_PRE_DIV,
    ST_PRE_WAIT,
    ST_RLD_DIV,
    ST_RLD_WAIT,
    ST_RESC_MUL,
    ST_RESC_DIV,
    ST_RESC_WAIT,
    ST_RESPOND
  } pwmpd_state_t;

  function automatic logic [15:0] sat16(input logic [NUM_W-1:0] v);
    sat16 = (v > NUM_W'(FULL_SCALE)) ? FULL_SCALE : v[15:0];
  endfunction

endpackage

>>> rtl/pwmpd_div.sv
// ============================================================================
// pwmpd_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 48-bit
// divisor. Quotient is valid while done is high.
// ============================================================================
module pwmpd_div
  import pwmpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  pwmpd_div_req_t req,
  output pwmpd_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(NUM_W - 1);

  logic             running;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  assign shifted = {rem, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == STEP_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      den <= req.divisor;
      quo <= req.dividend;
    end else if (running) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> rtl/pwmpd_compare_regs.sv
// ============================================================================
// pwmpd_compare_regs
// Per-channel compare registers; slots beyond the channel count read zero.
// ============================================================================
module pwmpd_compare_regs
  import pwmpd_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [1:0]  widx,
  input  logic [15:0] wdata,
  output logic [15:0] values [SLOT_COUNT]
);

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    if (g < CHANNEL_COUNT) begin : g_live
      logic [15:0] value;
      always_ff @(posedge clk) begin
        if (rst) begin
          value <= '0;
        end else if (we && widx == 2'(g)) begin
          value <= wdata;
        end
      end
      assign values[g] = value;
    end else begin : g_absent
      assign values[g] = '0;
    end
  end

endmodule

>>> rtl/pwmpd_core.sv
// ============================================================================
// pwm_period_duty_calculator_core
// Keeps prescaler, reload and channel compare values of a four-channel PWM
// timer and recomputes them on set-duty and set-frequency commands.
// ============================================================================
// A command is taken when start is high and busy is low; busy then stays high
// until the result beat, which is on result for one cycle with done high and
// cannot be stalled. All divisions by a variable run on one shared bit-serial
// divider and products on one 16x16 multiplier; the duty division by 65535
// is a shift-and-add on the registered product.
// A set-duty command runs the multiply, the shift-and-add and the result beat.
// A set-frequency command runs the prescaler division, a reload division from
// clock/frequency when the prescaler comes out zero, one rescale per channel
// and the result beat; a refused frequency goes straight to the result beat.
module pwm_period_duty_calculator_core
  import pwmpd_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pwmpd_request_t request,
  output logic           done,
  output pwmpd_result_t  result
);

  localparam logic [1:0] CH_LAST = 2'(CHANNEL_COUNT - 1);

  pwmpd_state_t state, state_next;

  logic [15:0]      prescale_value;
  logic [15:0]      auto_reload;
  logic [15:0]      compare_values [SLOT_COUNT];

  logic [1:0]       channel_r;
  logic [15:0]      duty_r;
  logic [31:0]      freq_r;
  logic [31:0]      clk_r;
  logic [DEN_W-1:0] den_r;
  logic             error_r;
  logic [31:0]      prod;
  logic [31:0]      duty_sum;
  logic [15:0]      new_prescale;
  logic [15:0]      new_reload;
  logic [1:0]       idx;

  logic [15:0]      mul_a;
  logic [15:0]      mul_b;
  logic             cmp_we;
  logic [1:0]       cmp_widx;
  logic [15:0]      cmp_wdata;
  logic             freq_bad;
  logic [15:0]      old_den;

  pwmpd_div_req_t div_req;
  pwmpd_div_rsp_t div_rsp;

  pwmpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pwmpd_compare_regs #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_cmp (
    .clk    (clk),
    .rst    (rst),
    .we     (cmp_we),
    .widx   (cmp_widx),
    .wdata  (cmp_wdata),
    .values (compare_values)
  );

  assign freq_bad = (request.target_frequency == '0) ||
                    (request.target_frequency >= request.timer_clock);
  assign old_den  = (auto_reload == '0) ? 16'd1 : auto_reload;

  // floor(x / 65535) for x below 2^32 - 2^17 + 2
  assign duty_sum = prod + 32'(prod[31:16]) + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    cmp_we     = 1'b0;
    cmp_widx   = channel_r;
    cmp_wdata  = sat16(div_rsp.quotient);
    mul_a      = auto_reload;
    mul_b      = duty_r;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (request.op == OP_SET_DUTY) begin
            state_next = ST_DUTY_MUL;
          end else if (freq_bad) begin
            state_next = ST_RESPOND;
          end else begin
            state_next = ST_PRE_DIV;
          end
        end
      end
      ST_DUTY_MUL: begin
        state_next = ST_DUTY_DIV;
      end
      ST_DUTY_DIV: begin
        cmp_we     = 1'b1;
        cmp_wdata  = duty_sum[31:16];
        state_next = ST_RESPOND;
      end
      ST_PRE_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = clk_r;
        div_req.divisor  = den_r;
        state_next       = ST_PRE_WAIT;
      end
      ST_PRE_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient != '0) ? ST_RESC_MUL : ST_RLD_DIV;
        end
      end
      ST_RLD_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = clk_r;
        div_req.divisor  = DEN_W'(freq_r);
        state_next       = ST_RLD_WAIT;
      end
      ST_RLD_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_RESC_MUL;
        end
      end
      ST_RESC_MUL: begin
        mul_a      = compare_values[idx];
        mul_b      = new_reload;
        state_next = ST_RESC_DIV;
      end
      ST_RESC_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = DEN_W'(old_den);
        state_next       = ST_RESC_WAIT;
      end
      ST_RESC_WAIT: begin
        if (div_rsp.done) begin
          cmp_we     = 1'b1;
          cmp_widx   = idx;
          state_next = (idx == CH_LAST) ? ST_RESPOND : ST_RESC_MUL;
        end
      end
      ST_RESPOND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // timer settings commit at the end of the rescale pass
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_value <= '0;
      auto_reload    <= FULL_SCALE;
    end else if (state == ST_RESC_WAIT && div_rsp.done && idx == CH_LAST) begin
      prescale_value <= new_prescale;
      auto_reload    <= new_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      channel_r <= request.channel;
      duty_r    <= request.duty;
      freq_r    <= request.target_frequency;
      clk_r     <= request.timer_clock;
      den_r     <= {request.target_frequency, 16'h0000} - DEN_W'(request.target_frequency);
      error_r   <= (request.op == OP_SET_FREQ) && freq_bad;
      idx       <= '0;
    end
    if (state == ST_DUTY_MUL || state == ST_RESC_MUL) begin
      prod <= 32'(mul_a) * 32'(mul_b);
    end
    if (state == ST_PRE_WAIT && div_rsp.done) begin
      new_prescale <= sat16(div_rsp.quotient);
      new_reload   <= FULL_SCALE;
    end
    if (state == ST_RLD_WAIT && div_rsp.done) begin
      new_prescale <= '0;
      new_reload   <= div_rsp.quotient[15:0];
    end
    if (state == ST_RESC_WAIT && div_rsp.done) begin
      idx <= idx + 1'b1;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESPOND);

  assign result.error         = error_r;
  assign result.prescale      = prescale_value;
  assign result.reload        = auto_reload;
  assign result.compare_one   = compare_values[0];
  assign result.compare_two   = compare_values[1];
  assign result.compare_three = compare_values[2];
  assign result.compare_four  = compare_values[3];

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("result beat not followed by idle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done) ||
                         (done && ($past(request.op) == OP_SET_FREQ) && error_r))
    else $error("accepted command did not start work");

  a_reload_nonzero: assert property (@(posedge clk) disable iff (rst)
    auto_reload != '0)
    else $error("reload value reached zero");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.done)
    else $error("divider restarted while delivering a quotient");

endmodule
